[hw/rtl/sss_pkg.sv]
// Shared types, constants and helpers for the sample set statistics block.
// No dependencies; imported by sss_datapath, sss_ctrl and the top level.
package sss_pkg;

   localparam int MaxSamplesDef  = 1024;
   localparam int ValueWidthDef  = 32;
   localparam int PctNum         = 5;
   localparam int PctDen         = 20;
   localparam int WeightWidth    = 16;
   localparam int OutValWidth    = 32;
   localparam int SdWidth        = 31;
   localparam int CountOutWidth  = 11;
   localparam int RspDataBits    = 7 * OutValWidth + OutValWidth + SdWidth + CountOutWidth + 1;
   localparam int RspDataWidth   = ((RspDataBits + 7) / 8) * 8;

   // percentile positions in twentieths
   localparam logic [4:0] PctK [PctNum] = '{5'd1, 5'd5, 5'd10, 5'd15, 5'd19};

   typedef enum logic [4:0] {
      ST_IDLE, ST_MDIV0, ST_MDIV, ST_MFIN, ST_VRD, ST_VLD, ST_VMUL, ST_VDIV0, ST_VDIV,
      ST_SQ0, ST_SQ, ST_CRD, ST_CLD, ST_SCAN, ST_TAIL, ST_CHK, ST_IMUL, ST_IADD, ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       div_mean;
      logic       div_var;
      logic       div_step;
      logic       mean_done;
      logic       acc_clr;
      logic       var_load;
      logic       mul_step;
      logic       sqrt_start;
      logic       sqrt_step;
      logic       cand_load;
      logic       scan_rd;
      logic       chk;
      logic       int_mul;
      logic       int_add;
      logic [2:0] pidx;
   } cmd_type;

   // floor(rem * 65536 / 20), rem in 0..19, as a constant table
   function automatic logic [WeightWidth-1:0] pct_weight(input logic [4:0] rem);
      logic [WeightWidth-1:0] w;
      case (rem)
         5'd0:    w = 16'd0;
         5'd1:    w = 16'd3276;
         5'd2:    w = 16'd6553;
         5'd3:    w = 16'd9830;
         5'd4:    w = 16'd13107;
         5'd5:    w = 16'd16384;
         5'd6:    w = 16'd19660;
         5'd7:    w = 16'd22937;
         5'd8:    w = 16'd26214;
         5'd9:    w = 16'd29491;
         5'd10:   w = 16'd32768;
         5'd11:   w = 16'd36044;
         5'd12:   w = 16'd39321;
         5'd13:   w = 16'd42598;
         5'd14:   w = 16'd45875;
         5'd15:   w = 16'd49152;
         5'd16:   w = 16'd52428;
         5'd17:   w = 16'd55705;
         5'd18:   w = 16'd58982;
         5'd19:   w = 16'd62259;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/sss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hw/rtl/sss_datapath.sv]
// Datapath: sample store, running sum/min/max, shared divider, serial squarer,
// square root, rank-count selection and percentile interpolation. Uses sss_pkg, sss_ram.
module sss_datapath #(
   parameter int MAX_SAMPLES = sss_pkg::MaxSamplesDef,
   parameter int VALUE_WIDTH = sss_pkg::ValueWidthDef
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sss_pkg::cmd_type                     cmd,
   input  logic [$clog2(MAX_SAMPLES)-1:0]       addr,
   input  logic signed [VALUE_WIDTH-1:0]        sample,
   output logic [$clog2(MAX_SAMPLES+1)-1:0]     cnt,
   output logic signed [VALUE_WIDTH-1:0]        mean_val,
   output logic [sss_pkg::SdWidth-1:0]          sd_val,
   output logic signed [VALUE_WIDTH-1:0]        min_val,
   output logic signed [VALUE_WIDTH-1:0]        max_val,
   output logic signed [VALUE_WIDTH-1:0]        pct_val [sss_pkg::PctNum],
   output logic                                 ovf
);
   import sss_pkg::*;

   localparam int VW   = VALUE_WIDTH;
   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int SUMW = VW + CW;
   localparam int DIVW = 2 * VW + CW;
   localparam int RW   = (DIVW + 1) / 2;
   localparam int SRW  = RW + 3;
   localparam int PW   = VW + 1 + WeightWidth;
   localparam int SDW  = (RW > SdWidth) ? RW : SdWidth;
   localparam logic signed [VW-1:0] VMax = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMin = {1'b1, {(VW-1){1'b0}}};

   // set state
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic signed [VW-1:0]   min_ff, min_in, max_ff, max_in;
   logic                   ovf_ff, ovf_in;
   logic [CW-1:0]          lo_ff [PctNum];
   logic [CW-1:0]          lo_in [PctNum];
   logic [4:0]             rem_ff [PctNum];
   logic [4:0]             rem_in [PctNum];
   logic                   room;
   logic [5:0]             rsum;

   // store
   logic [VW-1:0]          rd_raw;
   logic signed [VW-1:0]   rd_data;

   // divider
   logic [DIVW-1:0]        div_num_ff, div_num_in;
   logic [CW-1:0]          div_rem_ff, div_rem_in;
   logic                   div_neg_ff, div_neg_in;
   logic [CW:0]            div_trial, div_diff;
   logic                   div_ge;
   logic [SUMW-1:0]        sum_mag;
   logic signed [VW-1:0]   mean_ff, mean_in;

   // squarer
   logic [VW-1:0]          mplier_ff, mplier_in;
   logic [2*VW-1:0]        mcand_ff, mcand_in;
   logic [DIVW-1:0]        acc_ff, acc_in;
   logic signed [VW:0]     dev;
   logic [VW:0]            dev_abs;

   // root
   logic [2*RW-1:0]        sq_val_ff, sq_val_in;
   logic [RW-1:0]          root_ff, root_in;
   logic [SRW-1:0]         srem_ff, srem_in, sq_cur, sq_trial;
   logic [SDW-1:0]         root_x;

   // selection
   logic signed [VW-1:0]   cand_ff, cand_in;
   logic [CW-1:0]          lt_ff, lt_in, le_ff, le_in;
   logic                   scan_vld_ff;
   logic signed [VW-1:0]   a_ff [PctNum];
   logic signed [VW-1:0]   a_in [PctNum];
   logic signed [VW-1:0]   b_ff [PctNum];
   logic signed [VW-1:0]   b_in [PctNum];
   logic [CW-1:0]          lo1;

   // interpolation
   logic [PW-1:0]          prod_ff, prod_in;
   logic signed [VW-1:0]   pct_ff [PctNum];
   logic signed [VW-1:0]   pct_in [PctNum];
   logic [VW:0]            span;
   logic [VW:0]            interp;
   logic [WeightWidth-1:0] wt;

   sss_ram #(.WIDTH(VW), .DEPTH(MAX_SAMPLES)) u_store (
      .clock   (clock),
      .wr_en   (cmd.load & room),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (sample),
      .rd_addr (addr),
      .rd_data (rd_raw)
   );
   assign rd_data = rd_raw;

   // load and set state
   always_comb begin
      room   = cnt_ff < CW'(MAX_SAMPLES);
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      ovf_in = ovf_ff;
      rsum   = '0;
      for (int p = 0; p < PctNum; p++) begin
         lo_in[p]  = lo_ff[p];
         rem_in[p] = rem_ff[p];
      end
      if (cmd.clear) begin
         cnt_in = '0;
         sum_in = '0;
         min_in = VMax;
         max_in = VMin;
         ovf_in = 1'b0;
         for (int p = 0; p < PctNum; p++) begin
            lo_in[p]  = '0;
            rem_in[p] = '0;
         end
      end else if (cmd.load) begin
         if (room) begin
            cnt_in = cnt_ff + 1'b1;
            sum_in = sum_ff + SUMW'(sample);
            if (sample < min_ff) min_in = sample;
            if (sample > max_ff) max_in = sample;
            // position k*(n-1) advances by k per kept sample after the first
            if (cnt_ff != '0) begin
               for (int p = 0; p < PctNum; p++) begin
                  rsum = {1'b0, rem_ff[p]} + {1'b0, PctK[p]};
                  if (rsum >= 6'(PctDen)) begin
                     rem_in[p] = 5'(rsum - 6'(PctDen));
                     lo_in[p]  = lo_ff[p] + 1'b1;
                  end else begin
                     rem_in[p] = rsum[4:0];
                  end
               end
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // divider (restoring, one quotient bit per step) and mean sign fix
   always_comb begin
      div_trial  = {div_rem_ff, div_num_ff[DIVW-1]};
      div_ge     = div_trial >= {1'b0, cnt_ff};
      div_diff   = div_ge ? (div_trial - {1'b0, cnt_ff}) : div_trial;
      sum_mag    = (sum_ff < 0) ? SUMW'(-sum_ff) : SUMW'(sum_ff);
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_neg_in = div_neg_ff;
      mean_in    = mean_ff;
      if (cmd.div_mean) begin
         div_num_in = DIVW'(sum_mag);
         div_rem_in = '0;
         div_neg_in = sum_ff < 0;
      end else if (cmd.div_var) begin
         div_num_in = acc_ff;
         div_rem_in = '0;
      end else if (cmd.div_step) begin
         div_num_in = {div_num_ff[DIVW-2:0], div_ge};
         div_rem_in = div_diff[CW-1:0];
      end
      if (cmd.mean_done) begin
         mean_in = div_neg_ff ? -$signed(div_num_ff[VW-1:0]) : $signed(div_num_ff[VW-1:0]);
      end
   end

   // shift-add squarer accumulating squared deviations
   always_comb begin
      dev       = {rd_data[VW-1], rd_data} - {mean_ff[VW-1], mean_ff};
      dev_abs   = (dev < 0) ? (VW+1)'(-dev) : (VW+1)'(dev);
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      if (cmd.acc_clr) acc_in = '0;
      if (cmd.var_load) begin
         mplier_in = dev_abs[VW-1:0];
         mcand_in  = (2*VW)'(dev_abs[VW-1:0]);
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) acc_in = acc_ff + DIVW'(mcand_ff);
         mcand_in  = {mcand_ff[2*VW-2:0], 1'b0};
         mplier_in = mplier_ff >> 1;
      end
   end

   // digit-by-digit integer square root, two radicand bits per step
   always_comb begin
      sq_cur    = {srem_ff[SRW-3:0], sq_val_ff[2*RW-1 -: 2]};
      sq_trial  = SRW'({root_ff, 2'b01});
      sq_val_in = sq_val_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      if (cmd.sqrt_start) begin
         sq_val_in = (2*RW)'(div_num_ff);
         root_in   = '0;
         srem_in   = '0;
      end else if (cmd.sqrt_step) begin
         sq_val_in = {sq_val_ff[2*RW-3:0], 2'b00};
         if (sq_cur >= sq_trial) begin
            srem_in = sq_cur - sq_trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            srem_in = sq_cur;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   // rank counting: candidate is sorted[r] for lt <= r < le
   always_comb begin
      cand_in = cand_ff;
      lt_in   = lt_ff;
      le_in   = le_ff;
      lo1     = '0;
      for (int p = 0; p < PctNum; p++) begin
         a_in[p] = a_ff[p];
         b_in[p] = b_ff[p];
      end
      if (cmd.cand_load) begin
         cand_in = rd_data;
         lt_in   = '0;
         le_in   = '0;
      end else if (scan_vld_ff) begin
         if (rd_data < cand_ff)  lt_in = lt_ff + 1'b1;
         if (rd_data <= cand_ff) le_in = le_ff + 1'b1;
      end
      if (cmd.chk) begin
         for (int p = 0; p < PctNum; p++) begin
            lo1 = lo_ff[p] + 1'b1;
            if (lt_ff <= lo_ff[p] && lo_ff[p] < le_ff) a_in[p] = cand_ff;
            if (lt_ff <= lo1 && lo1 < le_ff) b_in[p] = cand_ff;
         end
      end
   end

   // interpolation: a + floor((b - a) * w / 65536)
   always_comb begin
      wt      = pct_weight(rem_ff[cmd.pidx]);
      span    = {b_ff[cmd.pidx][VW-1], b_ff[cmd.pidx]} - {a_ff[cmd.pidx][VW-1], a_ff[cmd.pidx]};
      prod_in = prod_ff;
      // zero weight: b may never have been set, result is a
      if (cmd.int_mul) prod_in = (wt == '0) ? '0 : PW'(span) * PW'(wt);
      interp  = {a_ff[cmd.pidx][VW-1], a_ff[cmd.pidx]} + (VW+1)'(prod_ff >> WeightWidth);
      for (int p = 0; p < PctNum; p++) begin
         pct_in[p] = pct_ff[p];
      end
      if (cmd.int_add) pct_in[cmd.pidx] = interp[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         sum_ff      <= '0;
         min_ff      <= VMax;
         max_ff      <= VMin;
         ovf_ff      <= 1'b0;
         scan_vld_ff <= 1'b0;
         for (int p = 0; p < PctNum; p++) begin
            lo_ff[p]  <= '0;
            rem_ff[p] <= '0;
         end
      end else begin
         cnt_ff      <= cnt_in;
         sum_ff      <= sum_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         ovf_ff      <= ovf_in;
         scan_vld_ff <= cmd.scan_rd;
         for (int p = 0; p < PctNum; p++) begin
            lo_ff[p]  <= lo_in[p];
            rem_ff[p] <= rem_in[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_neg_ff <= div_neg_in;
      mean_ff    <= mean_in;
      mplier_ff  <= mplier_in;
      mcand_ff   <= mcand_in;
      acc_ff     <= acc_in;
      sq_val_ff  <= sq_val_in;
      root_ff    <= root_in;
      srem_ff    <= srem_in;
      cand_ff    <= cand_in;
      lt_ff      <= lt_in;
      le_ff      <= le_in;
      prod_ff    <= prod_in;
      for (int p = 0; p < PctNum; p++) begin
         a_ff[p]   <= a_in[p];
         b_ff[p]   <= b_in[p];
         pct_ff[p] <= pct_in[p];
      end
   end

   assign root_x   = SDW'(root_ff);
   assign sd_val   = (root_x > SDW'({SdWidth{1'b1}})) ? {SdWidth{1'b1}} : root_x[SdWidth-1:0];
   assign cnt      = cnt_ff;
   assign mean_val = mean_ff;
   assign min_val  = min_ff;
   assign max_val  = max_ff;
   assign ovf      = ovf_ff;
   assign pct_val  = pct_ff;
endmodule

[hw/rtl/sss_ctrl.sv]
// Controller state machine: sequences load, mean, variance, root, selection
// and interpolation phases. Uses sss_pkg.
module sss_ctrl #(
   parameter int MAX_SAMPLES = sss_pkg::MaxSamplesDef,
   parameter int VALUE_WIDTH = sss_pkg::ValueWidthDef
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tlast,
   output logic                              req_tready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]  cnt,
   output sss_pkg::cmd_type                  cmd,
   output logic [$clog2(MAX_SAMPLES)-1:0]    addr
);
   import sss_pkg::*;

   localparam int VW   = VALUE_WIDTH;
   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int DIVW = 2 * VW + CW;
   localparam int RW   = (DIVW + 1) / 2;
   localparam int STW  = $clog2(DIVW);

   state_type      state_ff, state_in;
   logic [CW-1:0]  i_ff, i_in, j_ff, j_in, last_idx;
   logic [STW-1:0] step_ff, step_in;
   logic [2:0]     p_ff, p_in;
   logic           div_done, mul_done, sq_done;

   assign last_idx = cnt - 1'b1;
   assign div_done = step_ff == STW'(DIVW - 1);
   assign mul_done = step_ff == STW'(VW - 1);
   assign sq_done  = step_ff == STW'(RW - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid && req_tlast) state_in = ST_MDIV0;
         ST_MDIV0: state_in = ST_MDIV;
         ST_MDIV:  if (div_done) state_in = ST_MFIN;
         ST_MFIN:  state_in = ST_VRD;
         ST_VRD:   state_in = ST_VLD;
         ST_VLD:   state_in = ST_VMUL;
         ST_VMUL:  if (mul_done) state_in = (i_ff == last_idx) ? ST_VDIV0 : ST_VRD;
         ST_VDIV0: state_in = ST_VDIV;
         ST_VDIV:  if (div_done) state_in = ST_SQ0;
         ST_SQ0:   state_in = ST_SQ;
         ST_SQ:    if (sq_done) state_in = ST_CRD;
         ST_CRD:   state_in = ST_CLD;
         ST_CLD:   state_in = ST_SCAN;
         ST_SCAN:  if (j_ff == last_idx) state_in = ST_TAIL;
         ST_TAIL:  state_in = ST_CHK;
         ST_CHK:   state_in = (i_ff == last_idx) ? ST_IMUL : ST_CRD;
         ST_IMUL:  state_in = ST_IADD;
         ST_IADD:  state_in = (p_ff == 3'(PctNum - 1)) ? ST_OUT : ST_IMUL;
         ST_OUT:   if (rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // loop counters
   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      p_in    = p_ff;
      step_in = '0;
      case (state_ff) inside
         ST_MDIV, ST_VDIV, ST_SQ: step_in = step_ff + 1'b1;
         ST_VMUL: begin
            step_in = step_ff + 1'b1;
            if (mul_done) i_in = i_ff + 1'b1;
         end
         ST_MFIN, ST_SQ0: i_in = '0;
         ST_CLD:  j_in = '0;
         ST_SCAN: j_in = j_ff + 1'b1;
         ST_CHK:  begin
            i_in = i_ff + 1'b1;
            p_in = '0;
         end
         ST_IADD: p_in = p_ff + 1'b1;
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.pidx   = p_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      addr       = (state_ff == ST_SCAN) ? j_ff[AW-1:0] : i_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_MDIV0: cmd.div_mean = 1'b1;
         ST_MDIV:  cmd.div_step = 1'b1;
         ST_MFIN: begin
            cmd.mean_done = 1'b1;
            cmd.acc_clr   = 1'b1;
         end
         ST_VRD:   ;
         ST_VLD:   cmd.var_load = 1'b1;
         ST_VMUL:  cmd.mul_step = 1'b1;
         ST_VDIV0: cmd.div_var = 1'b1;
         ST_VDIV:  cmd.div_step = 1'b1;
         ST_SQ0:   cmd.sqrt_start = 1'b1;
         ST_SQ:    cmd.sqrt_step = 1'b1;
         ST_CRD:   ;
         ST_CLD:   cmd.cand_load = 1'b1;
         ST_SCAN:  cmd.scan_rd = 1'b1;
         ST_TAIL:  ;
         ST_CHK:   cmd.chk = 1'b1;
         ST_IMUL:  cmd.int_mul = 1'b1;
         ST_IADD:  cmd.int_add = 1'b1;
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            cmd.clear  = rsp_tready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         step_ff  <= '0;
         p_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         step_ff  <= step_in;
         p_ff     <= p_in;
      end
   end
endmodule

[hw/rtl/sample_set_statistics.sv]
// Load: one sample per cycle while idle; after the last transfer the block runs the mean
//   division, variance, square root, rank selection and interpolation; the n*n rank scan
//   over the store's read port dominates.
// One set at a time: req_tready is low from the last sample until the result
//   transfer. Reset (synchronous, active high) empties the set; the store is not cleared.
module sample_set_statistics #(
   parameter int MAX_SAMPLES = sss_pkg::MaxSamplesDef,
   parameter int VALUE_WIDTH = sss_pkg::ValueWidthDef
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input samples
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       req_tdata,  // sample
   input  logic                                   req_tlast,  // last sample of the set
   // results
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // mean, std_dev, minimum, maximum, pct_05, pct_25, pct_50, pct_75, pct_95,
   // sample_count, overflow
   output logic [sss_pkg::RspDataWidth-1:0]       rsp_tdata
);
   import sss_pkg::*;

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);

   cmd_type                      cmd;
   logic [AW-1:0]                addr;
   logic [CW-1:0]                cnt;
   logic signed [VALUE_WIDTH-1:0] sample;
   logic signed [VALUE_WIDTH-1:0] mean_val, min_val, max_val;
   logic signed [VALUE_WIDTH-1:0] pct_val [PctNum];
   logic [SdWidth-1:0]           sd_val;
   logic                         ovf;

   assign sample = req_tdata[VALUE_WIDTH-1:0];

   // sequencer: owns handshakes and all loop counters
   sss_ctrl #(.MAX_SAMPLES(MAX_SAMPLES), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cnt        (cnt),
      .cmd        (cmd),
      .addr       (addr)
   );

   // store plus arithmetic units
   sss_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .addr     (addr),
      .sample   (sample),
      .cnt      (cnt),
      .mean_val (mean_val),
      .sd_val   (sd_val),
      .min_val  (min_val),
      .max_val  (max_val),
      .pct_val  (pct_val),
      .ovf      (ovf)
   );

   // values go out as the low 32 bits of their sign-extended form
   assign rsp_tdata = RspDataWidth'({
      ovf,
      CountOutWidth'(cnt),
      OutValWidth'(pct_val[4]),
      OutValWidth'(pct_val[3]),
      OutValWidth'(pct_val[2]),
      OutValWidth'(pct_val[1]),
      OutValWidth'(pct_val[0]),
      OutValWidth'(max_val),
      OutValWidth'(min_val),
      sd_val,
      OutValWidth'(mean_val)
   });
endmodule

[verif/tb_sample_set_statistics.sv]
// Self-checking testbench for sample_set_statistics: streams sample sets, predicts
// mean, std dev, min/max, percentiles, count and overflow, and compares every result.
// Depends on hw/rtl/sss_pkg.sv and hw/rtl/sample_set_statistics.sv.
module tb_sample_set_statistics;
   timeunit 1ns;
   timeprecision 1ps;
   import sss_pkg::*;

   localparam int Cap = MaxSamplesDef;

   typedef struct packed {
      logic        last;
      logic [31:0] sample;
   } sample_xfer_type;

   typedef struct {
      logic signed [31:0] mean;
      logic [30:0]        std_dev;
      logic signed [31:0] minimum;
      logic signed [31:0] maximum;
      logic signed [31:0] pct [PctNum];
      logic [10:0]        sample_count;
      logic               overflow;
   } set_stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   sample_set_statistics u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sample_xfer_type pending_samples[$];
   set_stats_type   expected_stats[$];
   int errors = 0;
   int sets_done = 0;
   int samples_sent = 0;
   int send_idle_pct = 30;
   int recv_idle_pct = 54;
   logic hold_on = 1'b0;

   // predictor state for the set being loaded
   logic signed [31:0] set_store [Cap];
   int                 set_kept;
   logic signed [41:0] set_sum;
   logic signed [31:0] set_min, set_max;
   bit                 set_dropped;

   function automatic void clear_set();
      set_kept = 0;
      set_sum = '0;
      set_min = 32'sh7FFF_FFFF;
      set_max = 32'sh8000_0000;
      set_dropped = 1'b0;
   endfunction

   // absorb one accepted sample; at the last one queue the expected statistics
   function automatic void predict_sample(sample_xfer_type it);
      logic signed [31:0] x, tmp;
      logic signed [31:0] srt [Cap];
      logic signed [41:0] mean_w;
      logic signed [63:0] dev;
      logic [127:0] sq_sum, var_q, rsq;
      logic [63:0] root, cand;
      logic [63:0] r, lower, w;
      logic signed [63:0] a, b, v;
      logic [63:0] diff, prod;
      set_stats_type s;
      int n, i, j;
      x = it.sample;
      if (set_kept < Cap) begin
         set_store[set_kept] = x;
         set_kept++;
         set_sum += x;
         if (x < set_min) set_min = x;
         if (x > set_max) set_max = x;
      end else begin
         set_dropped = 1'b1;
      end
      if (!it.last) return;
      n = set_kept;
      mean_w = set_sum / n;   // truncates toward zero
      sq_sum = '0;
      for (i = 0; i < n; i++) begin
         dev = 64'(set_store[i]) - 64'(mean_w);
         if (dev < 0) dev = -dev;
         sq_sum += 128'(dev) * 128'(dev);
      end
      var_q = sq_sum / n;
      root = '0;
      for (i = 63; i >= 0; i--) begin
         cand = root | (64'd1 << i);
         rsq = 128'(cand) * 128'(cand);
         if (rsq <= var_q) root = cand;
      end
      if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
      for (i = 0; i < n; i++) srt[i] = set_store[i];
      for (i = 1; i < n; i++) begin
         tmp = srt[i];
         j = i - 1;
         while (j >= 0 && srt[j] > tmp) begin
            srt[j + 1] = srt[j];
            j--;
         end
         srt[j + 1] = tmp;
      end
      s.mean = mean_w[31:0];
      s.std_dev = root[30:0];
      s.minimum = set_min;
      s.maximum = set_max;
      for (i = 0; i < PctNum; i++) begin
         r = 64'(PctK[i]) * 64'(n - 1);
         lower = r / PctDen;
         w = ((r % PctDen) * 65536) / PctDen;
         a = srt[lower];
         v = a;
         if (w != 0 && lower + 1 < n) begin
            b = srt[lower + 1];
            diff = b - a;
            prod = diff * w;
            v = a + $signed(prod >> 16);
         end
         s.pct[i] = v[31:0];
      end
      s.sample_count = 11'(n);
      s.overflow = set_dropped;
      expected_stats.insert(expected_stats.size(), s);
      clear_set();
   endfunction

   function automatic logic [31:0] rand_sample(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($urandom_range(0, 400)) - 32'd200;
         2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   task automatic queue_set(int len, int mode);
      sample_xfer_type it;
      for (int k = 0; k < len; k++) begin
         it.sample = rand_sample(mode);
         it.last = (k == len - 1);
         pending_samples.insert(pending_samples.size(), it);
      end
   endtask

   task automatic queue_value(logic [31:0] val, logic lst);
      sample_xfer_type it;
      it.sample = val;
      it.last = lst;
      pending_samples.insert(pending_samples.size(), it);
   endtask

   // driver: one transfer offered per cycle unless idling or held by req_tready back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_sample({req_tlast, req_tdata});
            samples_sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               sample_xfer_type nx;
               nx = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nx.sample;
               req_tlast <= nx.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stats.size() == 0) begin
               $error("result transfer with nothing expected");
               errors++;
            end else begin
               set_stats_type e;
               e = expected_stats.pop_front();
               // layout from bit 0: mean, std_dev, min, max, pct x5, count, overflow
               if (rsp_tdata[31:0] !== e.mean) begin
                  $error("mean exp %h got %h", e.mean, rsp_tdata[31:0]); errors++;
               end
               if (rsp_tdata[62:32] !== e.std_dev) begin
                  $error("std_dev exp %h got %h", e.std_dev, rsp_tdata[62:32]); errors++;
               end
               if (rsp_tdata[94:63] !== e.minimum) begin
                  $error("minimum exp %h got %h", e.minimum, rsp_tdata[94:63]); errors++;
               end
               if (rsp_tdata[126:95] !== e.maximum) begin
                  $error("maximum exp %h got %h", e.maximum, rsp_tdata[126:95]); errors++;
               end
               for (int i = 0; i < PctNum; i++)
                  if (rsp_tdata[127 + i * 32 +: 32] !== e.pct[i]) begin
                     $error("pct[%0d] exp %h got %h", i, e.pct[i],
                            rsp_tdata[127 + i * 32 +: 32]);
                     errors++;
                  end
               if (rsp_tdata[297:287] !== e.sample_count) begin
                  $error("sample_count exp %0d got %0d", e.sample_count,
                         rsp_tdata[297:287]);
                  errors++;
               end
               if (rsp_tdata[298] !== e.overflow) begin
                  $error("overflow exp %0d got %0d", e.overflow, rsp_tdata[298]); errors++;
               end
               sets_done++;
            end
         end
         if (hold_on) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // long receiver hold while the sender keeps offering
   initial begin
      wait (samples_sent > 1080);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin
      int len;
      clear_set();
      // directed: lone samples at the extremes
      queue_value(32'h7FFF_FFFF, 1'b1);
      queue_value(32'h8000_0000, 1'b1);
      queue_value(32'h0000_0000, 1'b1);
      queue_value(32'hFFFF_FFFF, 1'b1);
      // pairs: widest spread (interpolation across full range), then two equal maxima
      queue_value(32'h8000_0000, 1'b0);
      queue_value(32'h7FFF_FFFF, 1'b1);
      queue_value(32'h7FFF_FFFF, 1'b0);
      queue_value(32'h7FFF_FFFF, 1'b1);
      // all-ones / alternating bits, negative means
      queue_value(32'h5555_5555, 1'b0);
      queue_value(32'hAAAA_AAAA, 1'b0);
      queue_value(32'hFFFF_FFFE, 1'b1);
      queue_value(32'hFFFF_FFFF, 1'b0);
      queue_value(32'hFFFF_FFFE, 1'b0);
      queue_value(32'h0000_0001, 1'b0);
      queue_value(32'hFFFF_FFFE, 1'b1);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // capacity reached: full store then drops, last one dropped too
      queue_set(Cap + 3, 0);
      // random sets, mostly small
      while (pending_samples.size() < 1250) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         queue_set(len, $urandom_range(0, 3));
      end
      wait (samples_sent > 1150);
      send_idle_pct = 54;
      recv_idle_pct = 30;
      wait (samples_sent > 1200);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait (pending_samples.size() == 0 && !req_tvalid);
      wait (expected_stats.size() == 0);
      repeat (200) @(posedge clock);
      $display("Checked %0d sample sets from %0d samples, incl. overflow and extremes.",
               sets_done, samples_sent);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #300ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

[files.f]
hw/rtl/sss_pkg.sv
hw/rtl/sss_ram.sv
hw/rtl/sss_datapath.sv
hw/rtl/sss_ctrl.sv
hw/rtl/sample_set_statistics.sv
verif/tb_sample_set_statistics.sv
